FILE: design/ps2mct_pkg.sv
// Shared types, constants and the clamp function for the PS/2 cursor tracker.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ps2mct_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_W      = 13;
    localparam int BYTE_W     = 8;
    // Signed working width: holds pointer plus 9-bit delta and the raw limit
    localparam int CMP_W = (COORD_BITS + 2 > CFG_W + 1) ? COORD_BITS + 2 : CFG_W + 1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(768);

    // Flags byte bit positions
    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_RIGHT = 1;
    localparam int FLAG_MOVE  = 3;
    localparam int FLAG_XSIGN = 4;
    localparam int FLAG_YSIGN = 5;

    typedef enum logic [1:0] {
        POS_FLAGS  = 2'd0,
        POS_XDELTA = 2'd1,
        POS_YDELTA = 2'd2
    } byte_pos_t;

    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] flags;
        logic [BYTE_W-1:0] x_delta;
        logic [BYTE_W-1:0] y_delta;
    } pkt_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
        logic                  right;
        logic                  ok;
    } res_t;

    // Clamp a signed coordinate to 0..limit-1; a zero limit acts as one and the
    // limit saturates at the coordinate range.
    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic [CMP_W-1:0] v,
        input logic [CFG_W-1:0] lim_cfg
    );
        logic [CMP_W-1:0] cap;
        logic [CMP_W-1:0] lim;
        logic [CMP_W-1:0] top;
        cap = CMP_W'(1) << COORD_BITS;
        lim = CMP_W'(lim_cfg);
        if (lim == '0)
        begin
            lim = CMP_W'(1);
        end
        if (lim > cap)
        begin
            lim = cap;
        end
        top = lim - CMP_W'(1);
        priority if (v[CMP_W-1])
        begin
            clamp_axis = '0;
        end
        else if (v >= lim)
        begin
            clamp_axis = top[COORD_BITS-1:0];
        end
        else
        begin
            clamp_axis = v[COORD_BITS-1:0];
        end
    endfunction

endpackage

FILE: design/ps2mct_framer.sv
// Input register and three-byte packet framing for the PS/2 cursor tracker.
// Depends on ps2mct_pkg.
`timescale 1ns / 1ps

module ps2mct_framer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ps2mct_pkg::BYTE_W-1:0] data_byte,
    input  logic                          from_mouse,
    output ps2mct_pkg::pkt_t              pkt,
    input  logic                          pkt_ready
);
    import ps2mct_pkg::*;

    logic              a_valid_reg;
    logic              a_valid_next;
    logic [BYTE_W-1:0] a_byte_reg;
    logic              a_mouse_reg;
    byte_pos_t         pos_reg;
    byte_pos_t         pos_next;
    logic [BYTE_W-1:0] flags_reg;
    logic [BYTE_W-1:0] flags_next;
    logic [BYTE_W-1:0] xd_reg;
    logic [BYTE_W-1:0] xd_next;
    logic              completes;
    logic              advance;
    logic              load;

    assign completes = a_mouse_reg && (pos_reg == POS_YDELTA);
    assign advance   = a_valid_reg && (!completes || pkt_ready);
    assign in_stall  = a_valid_reg && !advance;
    assign load      = in_valid && !in_stall;

    assign pkt.valid   = a_valid_reg && completes;
    assign pkt.flags   = flags_reg;
    assign pkt.x_delta = xd_reg;
    assign pkt.y_delta = a_byte_reg;

    always_comb
    begin
        pos_next     = pos_reg;
        flags_next   = flags_reg;
        xd_next      = xd_reg;
        a_valid_next = in_stall ? a_valid_reg : in_valid;
        if (advance && a_mouse_reg)
        begin
            unique case (pos_reg)
                POS_XDELTA:
                begin
                    xd_next  = a_byte_reg;
                    pos_next = POS_YDELTA;
                end
                POS_YDELTA:
                begin
                    pos_next = POS_FLAGS;
                end
                default:
                begin
                    flags_next = a_byte_reg;
                    pos_next   = POS_XDELTA;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            pos_reg     <= POS_FLAGS;
            flags_reg   <= '0;
            xd_reg      <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            pos_reg     <= pos_next;
            flags_reg   <= flags_next;
            xd_reg      <= xd_next;
        end
    end

    // Payload only; hold while stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_byte_reg  <= data_byte;
            a_mouse_reg <= from_mouse;
        end
    end

endmodule

FILE: design/ps2mct_tracker.sv
// Screen size registers, cursor position state and the add/clamp datapath.
// Depends on ps2mct_pkg.
`timescale 1ns / 1ps

module ps2mct_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [ps2mct_pkg::CFG_W-1:0] cfg_data,
    input  ps2mct_pkg::pkt_t             pkt,
    input  logic                         pkt_ready,
    output logic                         res_load,
    output ps2mct_pkg::res_t             res
);
    import ps2mct_pkg::*;

    logic [CFG_W-1:0]      width_reg;
    logic [CFG_W-1:0]      height_reg;
    logic [COORD_BITS-1:0] ptr_x_reg;
    logic [COORD_BITS-1:0] ptr_y_reg;
    logic [CMP_W-1:0]      dx;
    logic [CMP_W-1:0]      dy;
    logic [CMP_W-1:0]      nx;
    logic [CMP_W-1:0]      ny;
    logic                  move;

    assign res_load = pkt.valid && pkt_ready;
    assign move     = pkt.flags[FLAG_MOVE];

    // 9-bit deltas: sign comes from the flags byte
    assign dx = {{(CMP_W-BYTE_W){pkt.flags[FLAG_XSIGN]}}, pkt.x_delta};
    assign dy = {{(CMP_W-BYTE_W){pkt.flags[FLAG_YSIGN]}}, pkt.y_delta};

    always_comb
    begin
        nx = {{(CMP_W-COORD_BITS){1'b0}}, ptr_x_reg};
        ny = {{(CMP_W-COORD_BITS){1'b0}}, ptr_y_reg};
        if (move)
        begin
            nx = nx + dx;
            ny = ny - dy;   // screen Y grows downward
        end
    end

    assign res.x     = clamp_axis(nx, width_reg);
    assign res.y     = clamp_axis(ny, height_reg);
    assign res.left  = pkt.flags[FLAG_LEFT];
    assign res.right = pkt.flags[FLAG_RIGHT];
    assign res.ok    = move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            ptr_x_reg  <= '0;
            ptr_y_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default:           width_reg  <= width_reg;
                endcase
            end
            if (res_load)
            begin
                ptr_x_reg <= res.x;
                ptr_y_reg <= res.y;
            end
        end
    end

endmodule

FILE: design/ps2mct_outreg.sv
// Result register for the PS/2 cursor tracker output channel.
// Depends on ps2mct_pkg.
`timescale 1ns / 1ps

module ps2mct_outreg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_load,
    input  ps2mct_pkg::res_t res,
    output logic             res_ready,
    output logic             out_valid,
    input  logic             out_stall,
    output ps2mct_pkg::res_t out_res
);
    import ps2mct_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign res_ready = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        priority if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: design/ps2_mouse_cursor_tracker.sv
// PS/2 mouse cursor tracker top level.
// Depends on ps2mct_pkg, ps2mct_framer, ps2mct_tracker and ps2mct_outreg.
//
// Input channel: one controller byte per transfer (data_byte, from_mouse).
// Keyboard bytes are consumed and dropped. Mouse bytes are grouped in threes
// (flags, X delta, Y delta); the third byte of a group yields one result.
// Output channel: cursor_x, cursor_y, left_button, right_button, packet_ok.
// Configuration: cfg_we writes cfg_data into screen_width (index 0) or
// screen_height (index 1); write only while no byte is in flight.
//
// Result timing: the third mouse byte lands in the input register at its
// transfer edge, and the result register loads from it once that register
// can accept (empty, or its held result is taken); out_valid then rises.
// Throughput: one byte per cycle while in_stall is low; the add/clamp path
// between the input register and the result register is combinational.
// Reset: cursor at 0,0, framing at the flags byte, screen 1024 x 768.
// Stall: a held result stays on the output; bytes that do not complete a
// packet keep flowing. in_stall rises only when a completing byte meets a
// full, stalled result register.
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [ps2mct_pkg::CFG_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ps2mct_pkg::BYTE_W-1:0]     data_byte,
    input  logic                              from_mouse,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ps2mct_pkg::COORD_BITS-1:0] cursor_x,
    output logic [ps2mct_pkg::COORD_BITS-1:0] cursor_y,
    output logic                              left_button,
    output logic                              right_button,
    output logic                              packet_ok
);
    import ps2mct_pkg::*;

    pkt_t pkt;
    res_t res;
    res_t out_res;
    logic res_load;
    logic res_ready;

    ps2mct_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .from_mouse (from_mouse),
        .pkt        (pkt),
        .pkt_ready  (res_ready)
    );

    ps2mct_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pkt       (pkt),
        .pkt_ready (res_ready),
        .res_load  (res_load),
        .res       (res)
    );

    ps2mct_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign cursor_x     = out_res.x;
    assign cursor_y     = out_res.y;
    assign left_button  = out_res.left;
    assign right_button = out_res.right;
    assign packet_ok    = out_res.ok;

endmodule

FILE: design/ps2mct_checker.sv
// Port-level checks for the PS/2 cursor tracker, bound to the top level.
// Depends on ps2mct_pkg and ps2_mouse_cursor_tracker.
`timescale 1ns / 1ps

module ps2mct_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              from_mouse,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [ps2mct_pkg::COORD_BITS-1:0] cursor_x,
    input logic [ps2mct_pkg::COORD_BITS-1:0] cursor_y
);
    import ps2mct_pkg::*;

    // A stalled result holds its place and value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_x) && $stable(cursor_y))
        else $error("stalled result changed or dropped");

    // Input backpressure only comes from a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    // A fresh result follows an earlier transfer of a mouse byte
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && from_mouse, 2))
        else $error("result without a completing mouse byte");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .from_mouse (from_mouse),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y)
);

FILE: dv/ps2_mouse_cursor_tracker_tb.sv
// Self-checking testbench for the PS/2 mouse cursor tracker: directed table, then random
// packets under several screen sizes and idle/stall mixes, checked against a local predictor.
// Depends on ps2mct_pkg and ps2_mouse_cursor_tracker.
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker_tb;
    import ps2mct_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 80;
    localparam int N_STEPS      = 23;
    localparam int N_PHASES     = 5;
    localparam int TIMEOUT_NS   = 4_000_000;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
        logic                  right;
        logic                  ok;
    } cursor_report_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              mouse;
        logic              typed;
        cursor_report_t    want;
    } stim_row_t;

    typedef struct packed {
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [6:0]       tx;
        logic [6:0]       rx;
        logic             drift;
        logic             hold;
    } phase_t;

    // Typed expectations: after reset, a full positive X delta, a negative Y delta,
    // the lower clamp, and a flags byte without the motion bit.
    stim_row_t steps [N_STEPS] = '{
        '{8'h08, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, '{12'd0, 12'd0, 1'b0, 1'b0, 1'b1}},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h0B, 1'b1, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, '{12'd255, 12'd0, 1'b1, 1'b1, 1'b1}},
        '{8'h28, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h01, 1'b1, 1'b1, '{12'd255, 12'd255, 1'b0, 1'b0, 1'b1}},
        '{8'h18, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h80, 1'b1, 1'b1, '{12'd0, 12'd127, 1'b0, 1'b0, 1'b1}},
        '{8'h07, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{12'd0, 12'd127, 1'b1, 1'b1, 1'b0}},
        '{8'hF8, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h08, 1'b1, 1'b0, '0},
        '{8'h7F, 1'b1, 1'b0, '0},
        '{8'hFE, 1'b1, 1'b0, '0}
    };

    phase_t phases [N_PHASES] = '{
        '{13'd1024, 13'd768,  7'd0,  7'd0,  1'b0, 1'b0},
        '{13'd0,    13'd1,    7'd51, 7'd0,  1'b0, 1'b0},
        '{13'd4096, 13'd8191, 7'd0,  7'd51, 1'b1, 1'b0},
        '{13'd40,   13'd30,   7'd23, 7'd23, 1'b0, 1'b0},
        '{13'd4097, 13'd4095, 7'd0,  7'd0,  1'b1, 1'b1}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     data_byte;
    logic                  from_mouse;
    logic                  out_valid;
    logic                  out_stall;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic                  left_button;
    logic                  right_button;
    logic                  packet_ok;

    // Predictor state
    byte_pos_t             frame_pos;
    logic [BYTE_W-1:0]     pend_flags;
    logic [BYTE_W-1:0]     pend_dx;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic [CFG_W-1:0]      scr_w;
    logic [CFG_W-1:0]      scr_h;

    cursor_report_t reports_due [$];
    int  tx_pct = 0;
    int  rx_pct = 0;
    logic hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  error_count = 0;
    int  bytes_moved = 0;
    int  reports_checked = 0;
    int  blocked_cycles = 0;

    ps2_mouse_cursor_tracker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .from_mouse   (from_mouse),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .left_button  (left_button),
        .right_button (right_button),
        .packet_ok    (packet_ok)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic string fmt_report(input cursor_report_t r);
        return $sformatf("x=%0d y=%0d left=%0b right=%0b ok=%0b",
                         r.x, r.y, r.left, r.right, r.ok);
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    function automatic logic [COORD_BITS-1:0] clip_coord(input int v,
                                                         input logic [CFG_W-1:0] extent);
        int lim;
        lim = int'(extent);
        // zero acts as one; anything past the coordinate range saturates
        if (lim == 0)
            lim = 1;
        if (lim > (1 << COORD_BITS))
            lim = 1 << COORD_BITS;
        if (v < 0)
            return '0;
        if (v >= lim)
            return COORD_BITS'(lim - 1);
        return COORD_BITS'(v);
    endfunction

    function automatic void track_byte(input logic [BYTE_W-1:0] b, input logic m,
                                       output bit made, output cursor_report_t r);
        int nx;
        int ny;
        made = 1'b0;
        r = '0;
        if (!m)
            return;
        case (frame_pos)
            POS_XDELTA:
            begin
                pend_dx = b;
                frame_pos = POS_YDELTA;
            end
            POS_YDELTA:
            begin
                frame_pos = POS_FLAGS;
                nx = int'(cur_x);
                ny = int'(cur_y);
                if (pend_flags[FLAG_MOVE])
                begin
                    nx += pend_flags[FLAG_XSIGN] ? int'(pend_dx) - 256 : int'(pend_dx);
                    // screen Y grows downward
                    ny -= pend_flags[FLAG_YSIGN] ? int'(b) - 256 : int'(b);
                end
                cur_x = clip_coord(nx, scr_w);
                cur_y = clip_coord(ny, scr_h);
                r = '{cur_x, cur_y, pend_flags[FLAG_LEFT], pend_flags[FLAG_RIGHT],
                      pend_flags[FLAG_MOVE]};
                made = 1'b1;
            end
            default:
            begin
                pend_flags = b;
                frame_pos = POS_XDELTA;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic m,
                             input logic typed, input cursor_report_t want);
        bit made;
        cursor_report_t got;
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        from_mouse <= m;
        do
            @(posedge clk);
        while (in_stall);
        bytes_moved++;
        track_byte(b, m, made, got);
        if (typed)
        begin
            if (!made || got !== want)
                flag_error($sformatf("table row %s, predictor %s",
                                     fmt_report(want), fmt_report(got)));
            reports_due.push_back(want);
        end
        else if (made)
        begin
            reports_due.push_back(got);
        end
    endtask

    task automatic send_random(input int count, input logic drift);
        int moved;
        int pick;
        logic [BYTE_W-1:0] flags_b;
        logic [BYTE_W-1:0] dx_b;
        logic [BYTE_W-1:0] dy_b;
        moved = 0;
        while (moved < count)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_byte(BYTE_W'($urandom), 1'b0, 1'b0, '0);
            end
            else if (pick < 14)
            begin
                // stray mouse byte: shifts the framing for the rest of the stream
                send_byte(BYTE_W'($urandom), 1'b1, 1'b0, '0);
                moved++;
            end
            else
            begin
                flags_b = BYTE_W'($urandom);
                dx_b = BYTE_W'($urandom);
                dy_b = BYTE_W'($urandom);
                if ($urandom_range(9) < 8)
                    flags_b[FLAG_MOVE] = 1'b1;
                if (drift && $urandom_range(6) != 0)
                begin
                    // push toward the far corner so the upper clamp is reached
                    flags_b[FLAG_XSIGN] = 1'b0;
                    flags_b[FLAG_YSIGN] = 1'b1;
                    dx_b = BYTE_W'($urandom_range(160, 255));
                    dy_b = BYTE_W'($urandom_range(0, 95));
                end
                send_byte(flags_b, 1'b1, 1'b0, '0);
                if ($urandom_range(9) == 0)
                    send_byte(BYTE_W'($urandom), 1'b0, 1'b0, '0);
                send_byte(dx_b, 1'b1, 1'b0, '0);
                send_byte(dy_b, 1'b1, 1'b0, '0);
                moved += 3;
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        scr_w = w;
        scr_h = h;
    endtask

    // Receiver: random stall, plus one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    always @(posedge clk)
    begin : check_result
        cursor_report_t seen;
        cursor_report_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{cursor_x, cursor_y, left_button, right_button, packet_ok};
            if (reports_due.size() == 0)
            begin
                flag_error($sformatf("unexpected report %s", fmt_report(seen)));
            end
            else
            begin
                due = reports_due.pop_front();
                reports_checked++;
                if (seen !== due)
                    flag_error($sformatf("got %s, want %s", fmt_report(seen), fmt_report(due)));
            end
        end
        if (rst_n && in_valid && in_stall)
            blocked_cycles++;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("ps2_mouse_cursor_tracker_tb: done, errors");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_SCREEN_WIDTH;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        data_byte  <= '0;
        from_mouse <= 1'b0;
        frame_pos  = POS_FLAGS;
        pend_flags = '0;
        pend_dx    = '0;
        cur_x      = '0;
        cur_y      = '0;
        scr_w      = WIDTH_RESET;
        scr_h      = HEIGHT_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_STEPS; i++)
            send_byte(steps[i].value, steps[i].mouse, steps[i].typed, steps[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            set_screen(phases[p].w, phases[p].h);
            tx_pct = phases[p].tx;
            rx_pct = phases[p].rx;
            if (phases[p].hold)
                hold_req <= 1'b1;
            send_random(PHASE_ITEMS, phases[p].drift);
        end
        settle();

        $display("Covered %0d byte transfers and %0d cursor reports over %0d screen sizes",
                 bytes_moved, reports_checked, N_PHASES);
        $display("(zero, one, 4096 and 8191 among them); input blocked for %0d cycles",
                 blocked_cycles);
        if (error_count == 0)
            $display("ps2_mouse_cursor_tracker_tb: done, clean");
        else
            $display("ps2_mouse_cursor_tracker_tb: done, errors");
        $finish;
    end

endmodule
